/* rtl/erss_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the engine remote start sequencer.
// Used by every module under rtl; depends on nothing.
package erss_pkg;

	localparam int TACH_W   = 10;
	localparam int MS_W     = 13;
	localparam int RUN_W    = 26;
	localparam int REPORT_W = 15;
	localparam int MIN_W    = 10;
	localparam int CFG_AW   = 4;
	localparam int CFG_DW   = 32;
	localparam int S_DATA_W = 16;
	localparam int S_USER_W = 3;
	localparam int M_DATA_W = 24;

	localparam int DEF_MAX_ATTEMPTS = 3;
	localparam int DEF_TACH_BITS    = 10;

	localparam logic [MS_W-1:0]     CRANK_STEP_MS = 13'd50;
	localparam logic [MS_W-1:0]     SETTLE_MS     = 13'd1000;
	localparam logic [MS_W-1:0]     PAUSE_MS      = 13'd1000;
	localparam logic [MS_W-1:0]     PULSE_MS      = 13'd500;
	localparam logic [MS_W-1:0]     GLOW_STEP_MS  = 13'd2000;
	localparam logic [REPORT_W-1:0] REPORT_MS     = 15'd30000;
	localparam logic [15:0]         MS_PER_MIN    = 16'd60000;

	// floor(d / 60000) = floor((d >> 5) * MIN_RECIP >> 32) for every d below 2^26
	localparam logic [21:0] MIN_RECIP = 22'd2290650;

	localparam logic [9:0]  RST_RPM_THRESHOLD = 10'd300;
	localparam logic [9:0]  RST_RUN_MINUTES   = 10'd15;
	localparam logic [12:0] RST_MAX_CRANK_MS  = 13'd5000;
	localparam logic [11:0] RST_GLOW_BASE_MS  = 12'd3000;
	localparam logic [RUN_W-1:0] RST_PERIOD_MS = 26'd900000;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_GLOW   = 3'd1,
		PH_CRANK  = 3'd2,
		PH_SETTLE = 3'd3,
		PH_PAUSE  = 3'd4,
		PH_LOCK   = 3'd5,
		PH_UNLOCK = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		CMD_TICK     = 3'd0,
		CMD_START    = 3'd1,
		CMD_STOP     = 3'd2,
		CMD_LOCK     = 3'd3,
		CMD_UNLOCK   = 3'd4,
		CMD_HEAT_ON  = 3'd5,
		CMD_HEAT_OFF = 3'd6,
		CMD_NONE     = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		REG_RPM_THRESHOLD = 2'd0,
		REG_RUN_MINUTES   = 2'd1,
		REG_MAX_CRANK_MS  = 2'd2,
		REG_GLOW_BASE_MS  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [9:0]       rpm_threshold;
		logic [RUN_W-1:0] period_ms;
		logic [12:0]      max_crank_ms;
		logic [11:0]      glow_base_ms;
	} cfg_t;

	typedef struct packed {
		logic             report_due;
		logic [MIN_W-1:0] remaining_minutes;
		logic             busy_res;
		logic             timed_run;
		logic             armed;
		logic             heater_on;
		logic             unlock_pulse;
		logic             lock_pulse;
		logic             starter_on;
		logic             accessory_on;
		logic             ignition_on;
	} res_t;

endpackage

/* rtl/engine_remote_start_sequencer_unit.sv */
`timescale 1ns / 1ps
// Top level of the engine remote start sequencer.
// Depends on erss_pkg, erss_cfg, erss_core and erss_skid.
//
//  channel | direction | carries
//  s_*     | in        | tuser: command; tdata: tach_level
//  m_*     | out       | tdata: relay drives, flags, remaining_minutes, report_due
//  APB     | in/out    | rpm_threshold, run_period_minutes, max_crank_ms, glow_base_ms
//
// One request per cycle while s_tready is high: the state update is a single pass of
// logic between the state registers and the result register, which registers each result.
// Reset puts every timer and flag at zero and the sequence at idle; no clearing pass.
// The result register has a skid stage, so one more request is taken while a result
// stalls; s_tready drops only when both stages hold results.
module engine_remote_start_sequencer_unit #(
	parameter int MAX_ATTEMPTS = erss_pkg::DEF_MAX_ATTEMPTS,
	parameter int TACH_BITS    = erss_pkg::DEF_TACH_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [erss_pkg::S_DATA_W-1:0] s_tdata,  // [9:0] tach_level
	input  logic [erss_pkg::S_USER_W-1:0] s_tuser,  // [2:0] command
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] ignition_on [1] accessory_on [2] starter_on [3] lock_pulse [4] unlock_pulse
	// [5] heater_on [6] armed [7] timed_run [8] busy_res [18:9] remaining_minutes
	// [19] report_due
	output logic [erss_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [erss_pkg::CFG_AW-1:0]   paddr,
	input  logic [erss_pkg::CFG_DW-1:0]   pwdata,
	output logic [erss_pkg::CFG_DW-1:0]   prdata,
	output logic                           pready
);
	import erss_pkg::*;

	cfg_t cfg;
	res_t res;
	res_t out_res;
	logic step;

	assign step = s_tvalid && s_tready;

	erss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	erss_core #(
		.MAX_ATTEMPTS (MAX_ATTEMPTS),
		.TACH_BITS    (TACH_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.command    (s_tuser),
		.tach_level (s_tdata[TACH_W-1:0]),
		.cfg        (cfg),
		.res        (res)
	);

	erss_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {4'b0, out_res};

endmodule

/* rtl/erss_cfg.sv */
`timescale 1ns / 1ps
// APB register file for thresholds and timing, plus the run period in ms.
// Depends on erss_pkg.
module erss_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [erss_pkg::CFG_AW-1:0] paddr,
	input  logic [erss_pkg::CFG_DW-1:0] pwdata,
	output logic [erss_pkg::CFG_DW-1:0] prdata,
	output logic                         pready,
	output erss_pkg::cfg_t               cfg
);
	import erss_pkg::*;

	logic [9:0]       rpm_threshold_q;
	logic [9:0]       run_minutes_q;
	logic [12:0]      max_crank_q;
	logic [11:0]      glow_base_q;
	logic [RUN_W-1:0] period_q;
	logic             wr_en;
	reg_idx_t         idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpm_threshold_q <= RST_RPM_THRESHOLD;
			run_minutes_q   <= RST_RUN_MINUTES;
			max_crank_q     <= RST_MAX_CRANK_MS;
			glow_base_q     <= RST_GLOW_BASE_MS;
			period_q        <= RST_PERIOD_MS;
		end else if (wr_en) begin
			unique case (idx)
				REG_RPM_THRESHOLD: rpm_threshold_q <= pwdata[9:0];
				REG_RUN_MINUTES: begin
					run_minutes_q <= pwdata[9:0];
					// hold the period in ms so the run timer compares without a multiply
					period_q      <= RUN_W'(pwdata[9:0]) * RUN_W'(MS_PER_MIN);
				end
				REG_MAX_CRANK_MS:  max_crank_q <= pwdata[12:0];
				REG_GLOW_BASE_MS:  glow_base_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_RPM_THRESHOLD: prdata = CFG_DW'(rpm_threshold_q);
			REG_RUN_MINUTES:   prdata = CFG_DW'(run_minutes_q);
			REG_MAX_CRANK_MS:  prdata = CFG_DW'(max_crank_q);
			REG_GLOW_BASE_MS:  prdata = CFG_DW'(glow_base_q);
			default:           prdata = '0;
		endcase
	end

	assign cfg.rpm_threshold = rpm_threshold_q;
	assign cfg.period_ms     = period_q;
	assign cfg.max_crank_ms  = max_crank_q;
	assign cfg.glow_base_ms  = glow_base_q;

endmodule

/* rtl/erss_core.sv */
`timescale 1ns / 1ps
// Sequencer state and the per-request update: phases, timers, flags and report.
// Depends on erss_pkg.
module erss_core #(
	parameter int MAX_ATTEMPTS = erss_pkg::DEF_MAX_ATTEMPTS,
	parameter int TACH_BITS    = erss_pkg::DEF_TACH_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [erss_pkg::S_USER_W-1:0] command,
	input  logic [erss_pkg::TACH_W-1:0]  tach_level,
	input  erss_pkg::cfg_t               cfg,
	output erss_pkg::res_t               res
);
	import erss_pkg::*;

	localparam logic [TACH_W-1:0] TACH_MASK =
		(TACH_BITS >= TACH_W) ? {TACH_W{1'b1}} : TACH_W'((1 << TACH_BITS) - 1);
	localparam logic [1:0] ATTEMPT_LIMIT = 2'(MAX_ATTEMPTS);

	phase_t              phase_q, phase_n;
	logic [1:0]          attempt_q, attempt_n;
	logic [MS_W-1:0]     phase_ms_q, phase_ms_n;
	logic [MS_W-1:0]     glow_q, glow_n;
	logic [MS_W-1:0]     crank_q, crank_n;
	logic                armed_q, armed_n;
	logic                timed_q, timed_n;
	logic                heater_q, heater_n;
	logic                ign_q, ign_n;
	logic [RUN_W-1:0]    run_q, run_n;
	logic [REPORT_W-1:0] rep_q, rep_n;
	logic [MIN_W-1:0]    min_q, min_n;
	logic                report;

	logic [TACH_W-1:0] tach;
	logic [MS_W-1:0]   ph_inc;
	logic [MS_W:0]     crank_sum;
	logic              tach_above;
	logic              tach_at;
	logic [RUN_W-1:0]  left_ms;
	logic [42:0]       quot_prod;
	cmd_t              cmd;

	assign tach       = tach_level & TACH_MASK;
	assign cmd        = cmd_t'(command);
	assign tach_above = tach > cfg.rpm_threshold;
	assign tach_at    = tach >= cfg.rpm_threshold;
	assign ph_inc     = (phase_ms_q != {MS_W{1'b1}}) ? phase_ms_q + 1'b1 : phase_ms_q;
	assign crank_sum  = {1'b0, crank_q} + {1'b0, CRANK_STEP_MS};

	always_comb begin
		phase_n    = phase_q;
		attempt_n  = attempt_q;
		phase_ms_n = phase_ms_q;
		glow_n     = glow_q;
		crank_n    = crank_q;
		armed_n    = armed_q;
		timed_n    = timed_q;
		heater_n   = heater_q;
		ign_n      = ign_q;
		run_n      = run_q;
		rep_n      = rep_q;
		min_n      = min_q;
		report     = 1'b0;
		left_ms    = '0;
		quot_prod  = '0;

		if (cmd == CMD_TICK) begin
			if (timed_q) begin
				if (run_q != {RUN_W{1'b1}})    run_n = run_q + 1'b1;
				if (rep_q != {REPORT_W{1'b1}}) rep_n = rep_q + 1'b1;
			end
			unique case (phase_q)
				PH_GLOW: begin
					phase_ms_n = ph_inc;
					if (ph_inc >= glow_q) begin
						crank_n    = '0;
						phase_ms_n = '0;
						phase_n    = tach_above ? PH_SETTLE : PH_CRANK;
					end
				end
				PH_CRANK: begin
					phase_ms_n = ph_inc;
					if (ph_inc >= CRANK_STEP_MS) begin
						phase_ms_n = '0;
						crank_n    = crank_sum[MS_W] ? {MS_W{1'b1}} : crank_sum[MS_W-1:0];
						if (tach_above || (crank_sum > {1'b0, cfg.max_crank_ms}))
							phase_n = PH_SETTLE;
					end
				end
				PH_SETTLE: begin
					phase_ms_n = ph_inc;
					if (ph_inc >= SETTLE_MS) begin
						phase_ms_n = '0;
						if (tach_at) begin
							if (armed_q) begin
								run_n   = '0;
								rep_n   = '0;
								timed_n = 1'b1;
							end
							phase_n = PH_IDLE;
						end else begin
							ign_n   = 1'b0;
							if (attempt_q != 2'd3) attempt_n = attempt_q + 1'b1;
							glow_n  = glow_q + GLOW_STEP_MS;
							phase_n = PH_PAUSE;
						end
					end
				end
				PH_PAUSE: begin
					phase_ms_n = ph_inc;
					if (ph_inc >= PAUSE_MS) begin
						phase_ms_n = '0;
						if (attempt_q < ATTEMPT_LIMIT) begin
							ign_n   = 1'b1;
							phase_n = PH_GLOW;
						end else begin
							phase_n = PH_IDLE;
						end
					end
				end
				PH_LOCK, PH_UNLOCK: begin
					phase_ms_n = ph_inc;
					if (ph_inc >= PULSE_MS) begin
						phase_ms_n = '0;
						phase_n    = PH_IDLE;
					end
				end
				default: ;
			endcase

			// expiry and the periodic report act only once the sequence is done
			if (phase_n == PH_IDLE && timed_n) begin
				left_ms   = cfg.period_ms - run_n;
				quot_prod = 43'(left_ms[RUN_W-1:5]) * 43'(MIN_RECIP);
				if (run_n > cfg.period_ms) begin
					ign_n    = 1'b0;
					heater_n = 1'b0;
					run_n    = '0;
					timed_n  = 1'b0;
					min_n    = '0;
				end else if (rep_n > REPORT_MS) begin
					min_n  = quot_prod[32 +: MIN_W];
					rep_n  = '0;
					report = 1'b1;
				end
			end
		end else if (phase_q == PH_IDLE) begin
			case (cmd)
				CMD_START: begin
					if (!tach_above) begin
						attempt_n  = '0;
						glow_n     = MS_W'(cfg.glow_base_ms);
						crank_n    = '0;
						ign_n      = 1'b1;
						phase_n    = PH_GLOW;
						phase_ms_n = '0;
					end
				end
				CMD_STOP: begin
					ign_n    = 1'b0;
					heater_n = 1'b0;
					run_n    = '0;
					timed_n  = 1'b0;
				end
				CMD_LOCK: begin
					if (!armed_q) begin
						if (tach_at) begin
							timed_n = 1'b1;
							run_n   = '0;
							rep_n   = '0;
						end
						armed_n    = 1'b1;
						phase_n    = PH_LOCK;
						phase_ms_n = '0;
					end
				end
				CMD_UNLOCK: begin
					if (armed_q) begin
						timed_n    = 1'b0;
						armed_n    = 1'b0;
						phase_n    = PH_UNLOCK;
						phase_ms_n = '0;
					end
				end
				CMD_HEAT_ON:  heater_n = tach_at;
				CMD_HEAT_OFF: heater_n = 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			attempt_q  <= '0;
			phase_ms_q <= '0;
			glow_q     <= '0;
			crank_q    <= '0;
			armed_q    <= 1'b0;
			timed_q    <= 1'b0;
			heater_q   <= 1'b0;
			ign_q      <= 1'b0;
			run_q      <= '0;
			rep_q      <= '0;
			min_q      <= '0;
		end else if (step) begin
			phase_q    <= phase_n;
			attempt_q  <= attempt_n;
			phase_ms_q <= phase_ms_n;
			glow_q     <= glow_n;
			crank_q    <= crank_n;
			armed_q    <= armed_n;
			timed_q    <= timed_n;
			heater_q   <= heater_n;
			ign_q      <= ign_n;
			run_q      <= run_n;
			rep_q      <= rep_n;
			min_q      <= min_n;
		end
	end

	assign res.ignition_on       = ign_n;
	assign res.accessory_on      = ign_n;
	assign res.starter_on        = (phase_n == PH_CRANK);
	assign res.lock_pulse        = (phase_n == PH_LOCK);
	assign res.unlock_pulse      = (phase_n == PH_UNLOCK);
	assign res.heater_on         = heater_n;
	assign res.armed             = armed_n;
	assign res.timed_run         = timed_n;
	assign res.busy_res          = (phase_n != PH_IDLE);
	assign res.remaining_minutes = min_n;
	assign res.report_due        = report;

endmodule

/* rtl/erss_skid.sv */
`timescale 1ns / 1ps
// Two-entry result buffer: output register plus skid register.
// Depends on erss_pkg.
module erss_skid (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  erss_pkg::res_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output erss_pkg::res_t out_data
);
	import erss_pkg::*;

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_data_q;
	res_t skid_data_q;
	logic take;

	assign in_ready  = !skid_valid_q;
	assign take      = out_ready || !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && in_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q)  out_data_q <= skid_data_q;
			else if (in_valid) out_data_q <= in_data;
		end else if (in_valid && in_ready) begin
			// park the request while the output register is stalled
			skid_data_q <= in_data;
		end
	end

endmodule
